// ===== rtl/tpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types, format constants and the field table for the patch record
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

    // Header bytes
    localparam logic [7:0] MagicA     = 8'h47;   // 'G'
    localparam logic [7:0] MagicB     = 8'h50;   // 'P'
    localparam logic [7:0] FmtVersion = 8'h01;

    // Value widths carried in the type byte
    localparam logic [2:0] WidthByte = 3'd1;
    localparam logic [2:0] WidthWord = 3'd4;

    // Field table layout
    localparam int         ModSlots  = 8;
    localparam logic [15:0] ModBase  = 16'd40;
    localparam logic [15:0] SlotBase = 16'd50;
    localparam logic [15:0] SlotEnd  = 16'(50 + 3 * ModSlots);
    localparam logic [15:0] TiltBase = 16'd100;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] field_tag;
        logic [31:0] field_value;
        logic [2:0]  value_bytes;
        logic        status;
        logic        done_res;
    } out_item_t;

    // Results produced by one parsed byte: an optional update, then an
    // optional finish.
    typedef struct packed {
        logic      upd_valid;
        logic      fin_valid;
        out_item_t upd;
        out_item_t fin;
    } push_t;

    // Expected value width for a tag, 0 when the tag is not in the table.
    function automatic logic [2:0] table_width(input logic [15:0] tag);
        logic [15:0] k;
        logic [4:0]  r;
        logic [2:0]  w;
        w = 3'd0;
        k = 16'd0;
        r = 5'd0;
        if (tag >= 16'd1 && tag <= 16'd26)
        begin
            if (tag == 16'd1 || tag == 16'd2 || tag == 16'd12 || tag == 16'd24)
                w = WidthByte;
            else
                w = WidthWord;
        end
        else if (tag >= ModBase && tag <= ModBase + 16'd7)
        begin
            k = tag - ModBase;
            if (k == 16'd1 || k == 16'd2 || k == 16'd4 || k == 16'd5)
                w = WidthByte;
            else
                w = WidthWord;
        end
        else if (tag >= SlotBase && tag < SlotEnd)
        begin
            // offset is below 24: three compare/subtract steps give mod 3
            k = tag - SlotBase;
            r = k[4:0];
            if (r >= 5'd12)
                r = r - 5'd12;
            if (r >= 5'd6)
                r = r - 5'd6;
            if (r >= 5'd3)
                r = r - 5'd3;
            w = (r == 5'd2) ? WidthWord : WidthByte;
        end
        else if (tag >= TiltBase && tag <= TiltBase + 16'd3)
        begin
            // base is even, so the offset parity is the tag parity
            w = tag[0] ? WidthWord : WidthByte;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tpd_parser.sv =====
// ----------------------------------------------------------------------------
// tpd_parser
// Input register plus the header/record state machine. Each parsed byte
// yields up to two results (update, finish) for the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_parser
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tpd_pkg::in_item_t in_data,
    input  wire logic             space_ok,
    output tpd_pkg::push_t        push
);

    typedef enum logic [7:0] {
        PH_HDR0  = 8'b0000_0001,
        PH_HDR1  = 8'b0000_0010,
        PH_HDR2  = 8'b0000_0100,
        PH_TAGLO = 8'b0000_1000,
        PH_TAGHI = 8'b0001_0000,
        PH_TYPE  = 8'b0010_0000,
        PH_VALUE = 8'b0100_0000,
        PH_DRAIN = 8'b1000_0000
    } phase_t;

    logic              s1_valid_reg, s1_valid_next;
    tpd_pkg::in_item_t s1_data_reg;
    logic              advance;

    phase_t      phase_reg, phase_next;
    logic        hr_reg, hr_next;
    logic [15:0] tag_reg, tag_next;
    logic [7:0]  width_reg, width_next;
    logic [7:0]  left_reg, left_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  idx;
    logic [7:0]  b;
    logic        fin;

    assign advance  = s1_valid_reg && space_ok;
    assign in_ready = !s1_valid_reg || advance;
    assign s1_valid_next = (in_valid && in_ready) || (s1_valid_reg && !advance);
    assign b   = s1_data_reg.in_byte;
    assign fin = s1_data_reg.final_byte;
    assign idx = width_reg - left_reg;

    always_comb
    begin
        phase_next = phase_reg;
        hr_next    = hr_reg;
        tag_next   = tag_reg;
        width_next = width_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        push       = '0;
        if (advance)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    if (b != tpd_pkg::MagicA)
                        hr_next = 1'b1;
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (b != tpd_pkg::MagicB)
                        hr_next = 1'b1;
                    phase_next = PH_HDR2;
                end
                PH_HDR2:
                begin
                    if (b != tpd_pkg::FmtVersion)
                        hr_next = 1'b1;
                    phase_next = hr_next ? PH_DRAIN : PH_TAGLO;
                end
                PH_TAGLO:
                begin
                    tag_next   = {8'h00, b};
                    phase_next = PH_TAGHI;
                end
                PH_TAGHI:
                begin
                    tag_next   = {b, tag_reg[7:0]};
                    phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    width_next = b;
                    left_next  = b;
                    acc_next   = '0;
                    phase_next = (b == 8'd0) ? PH_TAGLO : PH_VALUE;
                end
                PH_VALUE:
                begin
                    // only the first four value bytes are kept
                    if (idx < 8'd4)
                        acc_next[{idx[1:0], 3'b000} +: 8] =
                            acc_reg[{idx[1:0], 3'b000} +: 8] | b;
                    left_next = left_reg - 8'd1;
                    if (left_next == 8'd0)
                    begin
                        if (width_reg != 8'd0 &&
                            {5'd0, tpd_pkg::table_width(tag_reg)} == width_reg)
                        begin
                            push.upd_valid           = 1'b1;
                            push.upd.field_tag       = tag_reg;
                            push.upd.field_value     = acc_next;
                            push.upd.value_bytes     = width_reg[2:0];
                        end
                        phase_next = PH_TAGLO;
                    end
                end
                PH_DRAIN:
                begin
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            if (fin)
            begin
                push.fin_valid     = 1'b1;
                push.fin.done_res  = 1'b1;
                // too short to hold a header counts as rejected
                push.fin.status    = hr_next || phase_reg == PH_HDR0 ||
                                     phase_reg == PH_HDR1;
                phase_next = PH_HDR0;
                hr_next    = 1'b0;
                tag_next   = '0;
                width_next = '0;
                left_next  = '0;
                acc_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= PH_HDR0;
            hr_reg       <= 1'b0;
            tag_reg      <= '0;
            width_reg    <= '0;
            left_reg     <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            phase_reg    <= phase_next;
            hr_reg       <= hr_next;
            tag_reg      <= tag_next;
            width_reg    <= width_next;
            left_reg     <= left_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
    end

`ifndef NO_ASSERTIONS
    a_fin_returns_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fin) |=> (phase_reg == PH_HDR0 && !hr_reg))
        else $error("parser did not return to header after final byte");

    a_update_from_value: assert property (@(posedge clk) disable iff (!rst_n)
        push.upd_valid |-> (advance && phase_reg == PH_VALUE))
        else $error("update produced outside value phase");

    a_drain_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DRAIN) |-> hr_reg)
        else $error("draining without a rejected header");
`endif

endmodule

`default_nettype wire

// ===== rtl/tpd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// tpd_result_fifo
// Four-entry result queue taking up to two results per cycle and issuing
// one beat per cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_result_fifo
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tpd_pkg::push_t    push,
    output logic                   space_ok,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tpd_pkg::out_item_t     out_data
);

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    tpd_pkg::out_item_t mem_reg [Depth];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [1:0]      num_push;
    logic            pop;
    logic [PtrW-1:0] fin_addr;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // room for two results, before any pop this cycle
    assign space_ok  = (count_reg <= CntW'(Depth - 2));
    assign num_push  = {1'b0, push.upd_valid} + {1'b0, push.fin_valid};
    assign fin_addr  = push.upd_valid ? wr_reg + PtrW'(1) : wr_reg;
    assign wr_next   = wr_reg + PtrW'(num_push);
    assign rd_next   = rd_reg + PtrW'(pop);
    assign count_next = count_reg + CntW'(num_push) - CntW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.upd_valid)
            mem_reg[wr_reg] <= push.upd;
        if (push.fin_valid)
            mem_reg[fin_addr] <= push.fin;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.upd_valid || push.fin_valid) |-> count_reg <= CntW'(Depth - 2))
        else $error("push into result queue without room");
`endif

endmodule

`default_nettype wire

// ===== rtl/tlv_patch_record_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tlv_patch_record_decoder_core
// Byte-serial decoder for stored patch buffers: header check, record
// assembly and field-table matching.
// ----------------------------------------------------------------------------
// Takes one buffer byte per cycle on the byte channel and emits update beats
// (tag plus little-endian value) for records that match the field table,
// followed by a finish beat on the byte flagged final. A byte is parsed
// straight out of the input register while the result queue has room, and its
// results are registered into a four-entry result queue. A byte is accepted
// every cycle as long as the queue holds no more than two results; a byte that
// closes a matching record on the final byte produces two result beats.
`default_nettype none

module tlv_patch_record_decoder_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire tpd_pkg::in_item_t  byte_data,
    output logic                    rec_valid,
    input  wire logic               rec_ready,
    output tpd_pkg::out_item_t      rec_data
);

    tpd_pkg::push_t push;
    logic           space_ok;

    tpd_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_valid),
        .in_ready (byte_ready),
        .in_data  (byte_data),
        .space_ok (space_ok),
        .push     (push)
    );

    tpd_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (rec_valid),
        .out_ready (rec_ready),
        .out_data  (rec_data)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tlv_patch_record_decoder_core: patch buffers go in
// as byte beats through a bursty sender, a local decoder predicts the update
// and finish beats, and a monitor behind a stalling receiver compares them.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RandomBytes  = 700;
    localparam int BurstMax     = 40;
    localparam int GapMax       = 6;
    localparam int HoldStart    = 300;   // bytes taken before the long stall
    localparam int HoldCycles   = 160;
    localparam int DrainCycles  = 20;
    localparam int CycleLimit   = 400000;
    localparam int PrintLimit   = 50;

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_HDR2, PH_TAG_LO, PH_TAG_HI, PH_TYPE, PH_VALUE, PH_DRAIN
    } phase_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_ready;
    tpd_pkg::in_item_t  byte_data  = '0;
    logic               rec_valid;
    logic               rec_ready  = 1'b0;
    tpd_pkg::out_item_t rec_data;

    // stimulus and expectations
    tpd_pkg::in_item_t  patch_bytes[$];
    logic [7:0]         build_q[$];
    tpd_pkg::out_item_t pending_records[$];
    tpd_pkg::out_item_t next_record;

    // local decoder state
    phase_t      parse_at   = PH_HDR0;
    logic        hdr_bad    = 1'b0;
    logic [15:0] rec_tag    = '0;
    logic [7:0]  rec_width  = '0;
    logic [7:0]  left_bytes = '0;
    logic [31:0] value_acc  = '0;

    int          error_count = 0;
    int          cycle_count = 0;
    int          bytes_taken = 0;
    logic        byte_taken  = 1'b0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          hold_left   = 0;
    logic        hold_done   = 1'b0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    tlv_patch_record_decoder_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_data   (rec_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [2:0] field_width(logic [15:0] tag);
        int t;
        t = int'(tag);
        if (t >= 1 && t <= 26)
            return (t == 1 || t == 2 || t == 12 || t == 24) ? tpd_pkg::WidthByte
                                                             : tpd_pkg::WidthWord;
        if (t >= 40 && t <= 47)
            return (t == 41 || t == 42 || t == 44 || t == 45) ? tpd_pkg::WidthByte
                                                               : tpd_pkg::WidthWord;
        if (t >= 50 && t < 50 + 3 * tpd_pkg::ModSlots)
            return ((t - 50) % 3 == 2) ? tpd_pkg::WidthWord : tpd_pkg::WidthByte;
        if (t >= 100 && t <= 103)
            return (t % 2 == 1) ? tpd_pkg::WidthWord : tpd_pkg::WidthByte;
        return 3'd0;
    endfunction

    function automatic void decode_byte(tpd_pkg::in_item_t it);
        phase_t             prior;
        tpd_pkg::out_item_t beat;
        int                 idx;
        logic [2:0]         want_w;
        prior = parse_at;
        case (parse_at)
            PH_HDR0:
            begin
                if (it.in_byte != tpd_pkg::MagicA)
                    hdr_bad = 1'b1;
                parse_at = PH_HDR1;
            end
            PH_HDR1:
            begin
                if (it.in_byte != tpd_pkg::MagicB)
                    hdr_bad = 1'b1;
                parse_at = PH_HDR2;
            end
            PH_HDR2:
            begin
                if (it.in_byte != tpd_pkg::FmtVersion)
                    hdr_bad = 1'b1;
                parse_at = hdr_bad ? PH_DRAIN : PH_TAG_LO;
            end
            PH_TAG_LO:
            begin
                rec_tag  = {8'h00, it.in_byte};
                parse_at = PH_TAG_HI;
            end
            PH_TAG_HI:
            begin
                rec_tag[15:8] = it.in_byte;
                parse_at      = PH_TYPE;
            end
            PH_TYPE:
            begin
                rec_width  = it.in_byte;
                left_bytes = it.in_byte;
                value_acc  = '0;
                parse_at   = (it.in_byte == 8'd0) ? PH_TAG_LO : PH_VALUE;
            end
            PH_VALUE:
            begin
                idx = int'(rec_width - left_bytes);
                if (idx < 4)
                    value_acc[8 * idx +: 8] = it.in_byte;
                left_bytes = left_bytes - 8'd1;
                if (left_bytes == 8'd0)
                begin
                    want_w = field_width(rec_tag);
                    if (want_w != 3'd0 && {5'd0, want_w} == rec_width)
                    begin
                        beat             = '0;
                        beat.field_tag   = rec_tag;
                        beat.field_value = value_acc;
                        beat.value_bytes = want_w;
                        pending_records.push_back(beat);
                    end
                    parse_at = PH_TAG_LO;
                end
            end
            default: ;
        endcase
        if (it.final_byte)
        begin
            beat          = '0;
            beat.status   = hdr_bad || prior == PH_HDR0 || prior == PH_HDR1;
            beat.done_res = 1'b1;
            pending_records.push_back(beat);
            parse_at   = PH_HDR0;
            hdr_bad    = 1'b0;
            rec_tag    = '0;
            rec_width  = '0;
            left_bytes = '0;
            value_acc  = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic void add_header(bit corrupt);
        int pick;
        build_q.push_back(tpd_pkg::MagicA);
        build_q.push_back(tpd_pkg::MagicB);
        build_q.push_back(tpd_pkg::FmtVersion);
        if (corrupt)
        begin
            pick = $urandom_range(0, 2);
            build_q[build_q.size() - 3 + pick] ^= 8'($urandom_range(1, 255));
        end
    endfunction

    function automatic void add_record(logic [15:0] tag, logic [7:0] width,
                                       logic [31:0] value);
        build_q.push_back(tag[7:0]);
        build_q.push_back(tag[15:8]);
        build_q.push_back(width);
        for (int i = 0; i < int'(width); i++)
            build_q.push_back((i < 4) ? value[8 * i +: 8] : 8'($urandom_range(0, 255)));
    endfunction

    // moves the assembled buffer into the send queue, flagging its last byte
    function automatic void close_buffer();
        tpd_pkg::in_item_t it;
        for (int i = 0; i < build_q.size(); i++)
        begin
            it.in_byte    = build_q[i];
            it.final_byte = (i == build_q.size() - 1);
            patch_bytes.push_back(it);
        end
        build_q.delete();
    endfunction

    function automatic logic [15:0] random_table_tag();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(1, 26));
            1: return 16'($urandom_range(40, 47));
            2: return 16'($urandom_range(50, 50 + 3 * tpd_pkg::ModSlots - 1));
            default: return 16'($urandom_range(100, 103));
        endcase
    endfunction

    function automatic void random_buffer();
        int          kind;
        int          cut;
        logic [15:0] tag;
        logic [7:0]  width;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: random bytes, often too short for a header
            repeat ($urandom_range(1, 10))
                build_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_header($urandom_range(0, 11) == 0);
            repeat ($urandom_range(0, 6))
            begin
                kind = $urandom_range(0, 19);
                if (kind < 12)
                begin
                    tag   = random_table_tag();
                    width = {5'd0, field_width(tag)};
                end
                else if (kind < 14)
                begin
                    tag   = random_table_tag();
                    width = 8'($urandom_range(0, 6));
                end
                else if (kind < 18)
                begin
                    tag   = 16'($urandom);
                    width = 8'($urandom_range(0, 6));
                end
                else if (kind == 18)
                begin
                    tag   = ($urandom_range(0, 1) == 0) ? random_table_tag() : 16'($urandom);
                    width = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(17, 255))
                                                        : 8'($urandom_range(5, 16));
                end
                else
                begin
                    tag   = 16'($urandom);
                    width = 8'd0;
                end
                add_record(tag, width, $urandom);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                // record cut short by the end of the buffer
                tag   = random_table_tag();
                width = {5'd0, field_width(tag)};
                add_record(tag, width, $urandom);
                cut = $urandom_range(1, int'(width) + 2);
                repeat (cut)
                    void'(build_q.pop_back());
            end
        end
        close_buffer();
    endfunction

    // ------------------------------------------------------------------
    // Byte channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        byte_taken = 1'b0;
        if (rst_n && byte_valid && byte_ready)
        begin
            decode_byte(byte_data);
            void'(patch_bytes.pop_front());
            bytes_taken++;
            byte_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(byte_valid && !byte_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                byte_valid <= 1'b0;
            end
            else if (patch_bytes.size() != 0)
            begin
                byte_valid <= 1'b1;
                byte_data  <= patch_bytes[0];
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, BurstMax);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, GapMax);
                end
                else
                    burst_left--;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    // one long stall once traffic is flowing, so the result queue fills up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && bytes_taken >= HoldStart)
            begin
                hold_left <= HoldCycles;
                hold_done <= 1'b1;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom);
                    2: ready_pattern = 16'($urandom | $urandom);
                    default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
                endcase
                pattern_age = 64;
            end
            pattern_age--;
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
            rec_ready <= ready_pattern[0] && (hold_left == 0);
        end
    end

    task automatic report_error(input string msg);
        if (error_count < PrintLimit)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want_val);
        if (got !== want_val)
            report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want_val));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rec_valid && rec_ready)
        begin
            if (pending_records.size() == 0)
                report_error($sformatf("unexpected beat tag=%0d done=%0b",
                                       rec_data.field_tag, rec_data.done_res));
            else
            begin
                next_record = pending_records.pop_front();
                check_field("field_tag", 32'(rec_data.field_tag), 32'(next_record.field_tag));
                check_field("field_value", rec_data.field_value, next_record.field_value);
                check_field("value_bytes", 32'(rec_data.value_bytes),
                            32'(next_record.value_bytes));
                check_field("status", 32'(rec_data.status), 32'(next_record.status));
                check_field("done_res", 32'(rec_data.done_res), 32'(next_record.done_res));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("FAIL tlv_patch_record_decoder_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int directed_bytes;

        // short buffers: final on header byte zero, one, and two
        build_q.push_back(tpd_pkg::MagicA);
        close_buffer();
        build_q.push_back(tpd_pkg::MagicA);
        build_q.push_back(tpd_pkg::MagicB);
        close_buffer();
        add_header(1'b0);
        close_buffer();

        // bad magic and version, then a byte that is drained
        build_q.push_back(8'h00);
        build_q.push_back(8'hFF);
        build_q.push_back(8'h00);
        build_q.push_back(tpd_pkg::MagicA);
        close_buffer();

        // byte field, zero-width record with an all-ones tag, word field on final
        add_header(1'b0);
        add_record(16'd1, 8'd1, 32'h0000_00FF);
        add_record(16'hFFFF, 8'd0, 32'h0);
        add_record(16'd103, 8'd4, 32'hFFFF_FFFF);
        close_buffer();

        // wide record on a listed tag, then a record truncated by the final byte
        add_header(1'b0);
        add_record(16'd5, 8'd5, 32'hA5A5_5A5A);
        add_record(16'd3, 8'd4, 32'h1234_5678);
        void'(build_q.pop_back());
        void'(build_q.pop_back());
        void'(build_q.pop_back());
        close_buffer();

        directed_bytes = patch_bytes.size();
        while (patch_bytes.size() < directed_bytes + RandomBytes)
            random_buffer();

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        while (patch_bytes.size() != 0)
            @(negedge clk);
        while (pending_records.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);

        if (error_count == 0)
            $display("PASS tlv_patch_record_decoder_core");
        else
            $display("FAIL tlv_patch_record_decoder_core");
        $finish;
    end

endmodule
